// ===== sv/srf_pkg.sv =====
// ----------------------------------------------------------------------------
// srf_pkg: shared types and constants
// Word types, register indexes and datapath widths of the segment force core.
// ----------------------------------------------------------------------------
`default_nettype none

package srf_pkg;

	// field widths
	localparam int CRD_W = 16;
	localparam int STR_W = 24;
	localparam int FRC_W = 24;
	localparam int IDX_W = 3;

	// datapath widths
	localparam int DIF_W    = CRD_W + 1;
	localparam int PRD_W    = 2 * DIF_W;
	localparam int SUM_W    = PRD_W + 1;
	localparam int RSQ_W    = 2 * CRD_W;
	localparam int NPR_W    = STR_W + DIF_W;
	localparam int SQ_W     = 2 * SUM_W;
	localparam int RP_W     = RSQ_W + SUM_W;
	localparam int NUM_W    = NPR_W + 6;
	localparam int DEN_W    = SUM_W + 1;
	localparam int DIV_BITS = FRC_W;
	localparam int CMP_W    = DEN_W + DIV_BITS;

	localparam logic [FRC_W-1:0] F_MAX = {1'b0, {(FRC_W-1){1'b1}}};
	localparam logic [FRC_W-1:0] F_MIN = {1'b1, {(FRC_W-1){1'b0}}};

	// register indexes
	localparam logic [IDX_W-1:0] REG_START_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_START_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_END_X   = 3'd2;
	localparam logic [IDX_W-1:0] REG_END_Y   = 3'd3;
	localparam logic [IDX_W-1:0] REG_OUTER   = 3'd4;
	localparam logic [IDX_W-1:0] REG_INNER   = 3'd5;
	localparam logic [IDX_W-1:0] REG_STRENGTH = 3'd6;

	typedef struct packed {
		logic signed [CRD_W-1:0] particle_x;
		logic signed [CRD_W-1:0] particle_y;
	} pos_t;

	typedef struct packed {
		logic signed [FRC_W-1:0] force_x;
		logic signed [FRC_W-1:0] force_y;
		logic                    in_range;
		logic                    saturated;
	} frc_t;

	// side information that rides along the divider
	typedef struct packed {
		logic zone;
		logic neg_x;
		logic neg_y;
		logic ovf_x;
		logic ovf_y;
	} srf_tag_t;

endpackage

`default_nettype wire

// ===== sv/srf_div.sv =====
// ----------------------------------------------------------------------------
// srf_div: two-lane pipelined restoring divider
// One quotient bit per stage for both force components over a shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module srf_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         src_valid,
	input  wire srf_pkg::srf_tag_t            src_tag,
	input  wire logic [srf_pkg::NUM_W-1:0]    num_x,
	input  wire logic [srf_pkg::NUM_W-1:0]    num_y,
	input  wire logic [srf_pkg::DEN_W-1:0]    den,
	output logic                              dst_valid,
	output srf_pkg::srf_tag_t                 dst_tag,
	output logic [srf_pkg::DIV_BITS-1:0]      quo_x,
	output logic [srf_pkg::DIV_BITS-1:0]      quo_y
);
	import srf_pkg::*;

	logic              v_s   [DIV_BITS];
	srf_tag_t          tag_s [DIV_BITS];
	logic [NUM_W-1:0]  rx_s  [DIV_BITS];
	logic [NUM_W-1:0]  ry_s  [DIV_BITS];
	logic [DEN_W-1:0]  d_s   [DIV_BITS];
	logic [DIV_BITS-1:0] qx_s [DIV_BITS];
	logic [DIV_BITS-1:0] qy_s [DIV_BITS];

	genvar k;
	generate
		for (k = 0; k < DIV_BITS; k++) begin : g_stage
			localparam int B = DIV_BITS - 1 - k;
			logic              pv;
			srf_tag_t          ptag;
			logic [NUM_W-1:0]  prx, pry;
			logic [DEN_W-1:0]  pd;
			logic [DIV_BITS-1:0] pqx, pqy;
			logic [CMP_W-1:0]  dsh;
			logic              gx, gy;

			// previous stage or divider input
			if (k == 0) begin : g_first
				assign pv   = src_valid;
				assign ptag = src_tag;
				assign prx  = num_x;
				assign pry  = num_y;
				assign pd   = den;
				assign pqx  = '0;
				assign pqy  = '0;
			end else begin : g_next
				assign pv   = v_s[k-1];
				assign ptag = tag_s[k-1];
				assign prx  = rx_s[k-1];
				assign pry  = ry_s[k-1];
				assign pd   = d_s[k-1];
				assign pqx  = qx_s[k-1];
				assign pqy  = qy_s[k-1];
			end

			// trial subtract of the shifted divisor
			assign dsh = CMP_W'(pd) << B;
			assign gx  = CMP_W'(prx) >= dsh;
			assign gy  = CMP_W'(pry) >= dsh;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en) begin
					v_s[k] <= pv;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					tag_s[k] <= ptag;
					d_s[k]   <= pd;
					rx_s[k]  <= gx ? NUM_W'(CMP_W'(prx) - dsh) : prx;
					ry_s[k]  <= gy ? NUM_W'(CMP_W'(pry) - dsh) : pry;
					qx_s[k]  <= pqx | (DIV_BITS'(gx) << B);
					qy_s[k]  <= pqy | (DIV_BITS'(gy) << B);
				end
			end
		end
	endgenerate

	assign dst_valid = v_s[DIV_BITS-1];
	assign dst_tag   = tag_s[DIV_BITS-1];
	assign quo_x     = qx_s[DIV_BITS-1];
	assign quo_y     = qy_s[DIV_BITS-1];

endmodule

`default_nettype wire

// ===== sv/segment_radial_force_core.sv =====
// ----------------------------------------------------------------------------
// segment_radial_force_core: force of a line segment on one particle
// Projects each particle onto the configured segment, tests the radial zone
// and divides out the saturated force, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              word
//  pos       in         pos_valid / pos_stall  pos_t particle position
//  frc       out        frc_valid / frc_stall  frc_t force and flags
//  cfg       in         cfg_we                 cfg_idx, cfg_data
//
//  one word per cycle while the output is not stalled; the pipeline holds five
//  arithmetic stages, the 24-stage quotient pipeline and the output register
//  a stalled output word freezes the whole pipeline in place
//  reset clears the configuration registers to zero and empties the pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module segment_radial_force_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       pos_valid,
	output logic                            pos_stall,
	input  wire srf_pkg::pos_t              pos,
	output logic                            frc_valid,
	input  wire logic                       frc_stall,
	output srf_pkg::frc_t                   frc,
	input  wire logic                       cfg_we,
	input  wire logic [srf_pkg::IDX_W-1:0]  cfg_idx,
	input  wire logic [srf_pkg::STR_W-1:0]  cfg_data
);
	import srf_pkg::*;

	// configuration registers
	logic signed [CRD_W-1:0] bx_q, by_q, ex_q, ey_q;
	logic        [CRD_W-1:0] ro_q, ri_q;
	logic signed [STR_W-1:0] st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bx_q <= '0; by_q <= '0; ex_q <= '0; ey_q <= '0;
			ro_q <= '0; ri_q <= '0; st_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_START_X:  bx_q <= cfg_data[CRD_W-1:0];
				REG_START_Y:  by_q <= cfg_data[CRD_W-1:0];
				REG_END_X:    ex_q <= cfg_data[CRD_W-1:0];
				REG_END_Y:    ey_q <= cfg_data[CRD_W-1:0];
				REG_OUTER:    ro_q <= cfg_data[CRD_W-1:0];
				REG_INNER:    ri_q <= cfg_data[CRD_W-1:0];
				REG_STRENGTH: st_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance
	logic en;
	assign en        = !(frc_valid && frc_stall);
	assign pos_stall = !en;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_dv, v_s30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s30 <= 1'b0;
		end else if (en) begin
			v_s1  <= pos_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s30 <= v_dv;
		end
	end

	// stage 1: offsets from the segment start
	logic signed [DIF_W-1:0] wx_s1, wy_s1, sx_s1, sy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= DIF_W'(pos.particle_x) - DIF_W'(bx_q);
			wy_s1 <= DIF_W'(pos.particle_y) - DIF_W'(by_q);
			sx_s1 <= DIF_W'(ex_q) - DIF_W'(bx_q);
			sy_s1 <= DIF_W'(ey_q) - DIF_W'(by_q);
		end
	end

	// stage 2: products
	logic signed [PRD_W-1:0] sxsx_s2, sysy_s2, wxsx_s2, wysy_s2, sxwy_s2, sywx_s2;
	logic        [RSQ_W-1:0] ri2_s2, ro2_s2;
	logic signed [NPR_W-1:0] nx_s2, ny_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sxsx_s2 <= PRD_W'(sx_s1) * PRD_W'(sx_s1);
			sysy_s2 <= PRD_W'(sy_s1) * PRD_W'(sy_s1);
			wxsx_s2 <= PRD_W'(wx_s1) * PRD_W'(sx_s1);
			wysy_s2 <= PRD_W'(wy_s1) * PRD_W'(sy_s1);
			sxwy_s2 <= PRD_W'(sx_s1) * PRD_W'(wy_s1);
			sywx_s2 <= PRD_W'(sy_s1) * PRD_W'(wx_s1);
			ri2_s2  <= RSQ_W'(ri_q) * RSQ_W'(ri_q);
			ro2_s2  <= RSQ_W'(ro_q) * RSQ_W'(ro_q);
			// x numerator uses -sy, folded into the sign later
			nx_s2   <= NPR_W'(st_q) * NPR_W'(sy_s1);
			ny_s2   <= NPR_W'(st_q) * NPR_W'(sx_s1);
		end
	end

	// stage 3: sums
	logic        [SUM_W-1:0] den_s3;
	logic signed [SUM_W-1:0] dot_s3, c_s3;
	logic        [RSQ_W-1:0] ri2_s3, ro2_s3;
	logic signed [NPR_W-1:0] nx_s3, ny_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3 <= SUM_W'(sxsx_s2) + SUM_W'(sysy_s2);
			dot_s3 <= SUM_W'(wxsx_s2) + SUM_W'(wysy_s2);
			c_s3   <= SUM_W'(sxwy_s2) - SUM_W'(sywx_s2);
			ri2_s3 <= ri2_s2;
			ro2_s3 <= ro2_s2;
			nx_s3  <= nx_s2;
			ny_s3  <= ny_s2;
		end
	end

	// stage 4: squares for the zone test, magnitudes and signs
	logic [SUM_W-1:0] ac_c;
	assign ac_c = c_s3[SUM_W-1] ? SUM_W'(-c_s3) : SUM_W'(c_s3);

	logic [SQ_W-1:0]  csq_s4;
	logic [RP_W-1:0]  lo_s4, hi_s4;
	logic [SUM_W-1:0] ac_s4;
	logic [NPR_W-1:0] anx_s4, any_s4;
	logic             pre_s4, negx_s4, negy_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			csq_s4  <= SQ_W'(ac_c) * SQ_W'(ac_c);
			lo_s4   <= RP_W'(ri2_s3) * RP_W'(den_s3);
			hi_s4   <= RP_W'(ro2_s3) * RP_W'(den_s3);
			ac_s4   <= ac_c;
			anx_s4  <= nx_s3[NPR_W-1] ? NPR_W'(-nx_s3) : NPR_W'(nx_s3);
			any_s4  <= ny_s3[NPR_W-1] ? NPR_W'(-ny_s3) : NPR_W'(ny_s3);
			pre_s4  <= (den_s3 != '0) && !dot_s3[SUM_W-1]
			           && (SUM_W'(dot_s3) <= den_s3) && (c_s3 != '0);
			// -sy numerator: negative when st*sy and c agree in sign
			negx_s4 <= (nx_s3 != '0) && (nx_s3[NPR_W-1] == c_s3[SUM_W-1]);
			negy_s4 <= (ny_s3 != '0) && (ny_s3[NPR_W-1] != c_s3[SUM_W-1]);
		end
	end

	// stage 5: zone decision and divider operands
	logic [NUM_W-1:0] numx_c, numy_c;
	logic [DEN_W-1:0] dd_c;
	assign numx_c = (NUM_W'(anx_s4) << 5) + NUM_W'(ac_s4);
	assign numy_c = (NUM_W'(any_s4) << 5) + NUM_W'(ac_s4);
	assign dd_c   = DEN_W'(ac_s4) << 1;

	logic [NUM_W-1:0] numx_s5, numy_s5;
	logic [DEN_W-1:0] dd_s5;
	srf_tag_t         tag_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s5      <= numx_c;
			numy_s5      <= numy_c;
			dd_s5        <= dd_c;
			tag_s5.zone  <= pre_s4 && (csq_s4 >= SQ_W'(lo_s4)) && (csq_s4 <= SQ_W'(hi_s4));
			tag_s5.neg_x <= negx_s4;
			tag_s5.neg_y <= negy_s4;
			tag_s5.ovf_x <= CMP_W'(numx_c) >= (CMP_W'(dd_c) << DIV_BITS);
			tag_s5.ovf_y <= CMP_W'(numy_c) >= (CMP_W'(dd_c) << DIV_BITS);
		end
	end

	// quotient pipeline
	srf_tag_t            tag_dv;
	logic [DIV_BITS-1:0] qx_dv, qy_dv;

	srf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (v_s5),
		.src_tag   (tag_s5),
		.num_x     (numx_s5),
		.num_y     (numy_s5),
		.den       (dd_s5),
		.dst_valid (v_dv),
		.dst_tag   (tag_dv),
		.quo_x     (qx_dv),
		.quo_y     (qy_dv)
	);

	// saturation and sign
	logic clipx_c, clipy_c;
	logic [FRC_W-1:0] fx_c, fy_c;
	assign clipx_c = tag_dv.zone && (tag_dv.ovf_x
	                 || (!tag_dv.neg_x && qx_dv > F_MAX)
	                 || (tag_dv.neg_x && qx_dv > F_MIN));
	assign clipy_c = tag_dv.zone && (tag_dv.ovf_y
	                 || (!tag_dv.neg_y && qy_dv > F_MAX)
	                 || (tag_dv.neg_y && qy_dv > F_MIN));
	assign fx_c = !tag_dv.zone ? '0 :
	              clipx_c ? (tag_dv.neg_x ? F_MIN : F_MAX) :
	              (tag_dv.neg_x ? FRC_W'(-qx_dv) : qx_dv);
	assign fy_c = !tag_dv.zone ? '0 :
	              clipy_c ? (tag_dv.neg_y ? F_MIN : F_MAX) :
	              (tag_dv.neg_y ? FRC_W'(-qy_dv) : qy_dv);

	// output register
	frc_t frc_s30;

	always_ff @(posedge clk) begin
		if (en) begin
			frc_s30.force_x   <= fx_c;
			frc_s30.force_y   <= fy_c;
			frc_s30.in_range  <= tag_dv.zone;
			frc_s30.saturated <= clipx_c || clipy_c;
		end
	end

	assign frc_valid = v_s30;
	assign frc       = frc_s30;

	// checks
	a_out_of_zone_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(frc_valid && !frc.in_range) |->
		(frc.force_x == '0 && frc.force_y == '0 && !frc.saturated))
		else $error("out-of-zone word carries force");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(frc_valid && frc.saturated) |->
		(frc.force_x == F_MAX || frc.force_x == F_MIN
		 || frc.force_y == F_MAX || frc.force_y == F_MIN))
		else $error("saturated word without a clipped component");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(frc_valid && frc_stall) |=> ($stable(v_dv) && $stable(qx_dv) && $stable(v_s5)))
		else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire
